// ----- rtl/core/yuv420_privacy_mask_assert.svh -----
// ----------------------------------------------------------------------------
// yuv420_privacy_mask assertion macros
// Shared property forms for the privacy mask checker.
// ----------------------------------------------------------------------------
`ifndef YUV420_PRIVACY_MASK_ASSERT_SVH
`define YUV420_PRIVACY_MASK_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset
`define YPM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ypm: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset
`define YPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ypm: next-cycle check failed");

`endif

// ----- rtl/core/ypm_pkg.sv -----
// ----------------------------------------------------------------------------
// ypm_pkg
// Types, widths and codes shared by the YUV 4:2:0 privacy mask block.
// ----------------------------------------------------------------------------
package ypm_pkg;

  localparam int COORD_W    = 12;
  localparam int SAMPLE_W   = 8;
  localparam int MODE_W     = 2;
  localparam int RECT_W     = 4 * COORD_W;
  localparam int CFG_DATA_W = RECT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int RECT_SLOTS = 4;

  localparam int DEF_MASK_COUNT = 4;
  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  // Plane codes
  localparam logic [MODE_W-1:0] MODE_LUMA = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CB   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CR   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASK_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_RECT_0 = 3'd1;

  // Fill values for covered samples
  localparam logic [SAMPLE_W-1:0] LUMA_FILL   = 8'd0;
  localparam logic [SAMPLE_W-1:0] CHROMA_FILL = 8'd128;

  // Rectangle as packed in its register: left in the low bits, bottom on top
  typedef struct packed {
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
  } rect_t;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [SAMPLE_W-1:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_out;
    logic                covered;
  } out_item_t;

  // Position of the sample under test, handed to each rectangle matcher
  typedef struct packed {
    logic               is_luma;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } probe_t;

endpackage

// ----- rtl/core/ypm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ypm_cfg_regs
// Write-only register file: mask enable and the mask rectangles.
// ----------------------------------------------------------------------------
module ypm_cfg_regs #(
  parameter int MASK_COUNT = ypm_pkg::DEF_MASK_COUNT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [ypm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ypm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             mask_enable,
  output ypm_pkg::rect_t [MASK_COUNT-1:0]  rects
);

  // Enable register
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_enable <= 1'b0;
    end else if (cfg_wr_en && cfg_index == ypm_pkg::REG_MASK_ENABLE) begin
      mask_enable <= cfg_data[0];
    end
  end

  // One rectangle register per implemented mask; higher slots are dropped
  for (genvar k = 0; k < MASK_COUNT; k++) begin : g_rect
    localparam logic [ypm_pkg::CFG_IDX_W-1:0] RECT_IDX =
      ypm_pkg::REG_MASK_RECT_0 + ypm_pkg::CFG_IDX_W'(k);

    always_ff @(posedge clk) begin
      if (rst) begin
        rects[k] <= '0;
      end else if (cfg_wr_en && cfg_index == RECT_IDX) begin
        rects[k] <= ypm_pkg::rect_t'(cfg_data[ypm_pkg::RECT_W-1:0]);
      end
    end
  end

endmodule

// ----- rtl/core/ypm_rect_match.sv -----
// ----------------------------------------------------------------------------
// ypm_rect_match
// Tests one sample position against one mask rectangle.
// ----------------------------------------------------------------------------
module ypm_rect_match (
  input  ypm_pkg::rect_t  rect,
  input  ypm_pkg::probe_t probe,
  output logic            hit
);

  logic                         active;
  logic [ypm_pkg::COORD_W:0]    row_ext;
  logic [ypm_pkg::COORD_W-1:0]  col_lo;
  logic [ypm_pkg::COORD_W-1:0]  col_hi;
  logic                         row_ok;
  logic                         col_ok;

  // A rectangle with any zero field is unused
  assign active = (rect.left != '0) && (rect.top != '0) &&
                  (rect.right != '0) && (rect.bottom != '0);

  // Chroma rows map to the odd luma row below them; columns halve
  always_comb begin
    if (probe.is_luma) begin
      row_ext = {1'b0, probe.row};
      col_lo  = rect.left;
      col_hi  = rect.right;
    end else begin
      row_ext = {probe.row, 1'b1};
      col_lo  = {1'b0, rect.left[ypm_pkg::COORD_W-1:1]};
      col_hi  = {1'b0, rect.right[ypm_pkg::COORD_W-1:1]};
    end
  end

  assign row_ok = (row_ext >= {1'b0, rect.top}) && (row_ext <= {1'b0, rect.bottom});
  assign col_ok = (probe.col >= col_lo) && (probe.col < col_hi);
  assign hit    = active && row_ok && col_ok;

endmodule

// ----- rtl/core/yuv420_privacy_mask.sv -----
// ----------------------------------------------------------------------------
// yuv420_privacy_mask
// Blanks privacy rectangles in planar YUV 4:2:0 video, one sample per item.
// ----------------------------------------------------------------------------
//   channel  | signals                          | item
//   ---------+----------------------------------+-----------------------------
//   input    | in_valid, in_stall, in_item      | mode, row, col, sample_in
//   output   | out_valid, out_stall, out_item   | sample_out, covered
//   config   | cfg_wr_en, cfg_index, cfg_data   | enable, MASK_COUNT rectangles
//
// One item per clock sustained while out_stall is low; each item passes through
// the input register, then the mask compare, into the result register.
// rst is synchronous: clears both valid flags and all configuration, and
// holds in_stall high while asserted.
// Outside reset, in_stall rises only when both the input and result registers
// are full and out_stall is high; the input register acts as the skid stage.
// ----------------------------------------------------------------------------
module yuv420_privacy_mask #(
  parameter int MASK_COUNT = ypm_pkg::DEF_MASK_COUNT,
  parameter int MAX_WIDTH  = ypm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ypm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  ypm_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output ypm_pkg::out_item_t             out_item,
  input  logic                           cfg_wr_en,
  input  logic [ypm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ypm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int LW = ypm_pkg::COORD_W + 1;
  localparam logic [LW-1:0] LUMA_ROWS   = LW'(MAX_HEIGHT);
  localparam logic [LW-1:0] LUMA_COLS   = LW'(MAX_WIDTH);
  localparam logic [LW-1:0] CHROMA_ROWS = LW'(MAX_HEIGHT / 2);
  localparam logic [LW-1:0] CHROMA_COLS = LW'(MAX_WIDTH / 2);

  logic                             mask_enable;
  ypm_pkg::rect_t [MASK_COUNT-1:0]  rects;

  logic                             stage_valid;
  ypm_pkg::in_item_t                stage_item;
  logic                             out_advance;
  logic                             in_take;

  ypm_pkg::probe_t                  probe;
  logic [MASK_COUNT-1:0]            rect_hit;
  logic                             is_chroma;
  logic                             in_frame;
  logic                             hit;
  ypm_pkg::out_item_t               out_item_next;

  ypm_cfg_regs #(
    .MASK_COUNT (MASK_COUNT)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mask_enable (mask_enable),
    .rects       (rects)
  );

  // Handshake: result register frees up when empty or being taken
  assign out_advance = !out_valid || !out_stall;
  assign in_stall    = rst || (stage_valid && !out_advance);
  assign in_take     = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_take) begin
      stage_valid <= 1'b1;
    end else if (out_advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_item <= in_item;
    end
  end

  // Compare against every mask in parallel
  assign probe.is_luma = (stage_item.mode == ypm_pkg::MODE_LUMA);
  assign probe.row     = stage_item.row;
  assign probe.col     = stage_item.col;

  for (genvar k = 0; k < MASK_COUNT; k++) begin : g_match
    ypm_rect_match u_match (
      .rect  (rects[k]),
      .probe (probe),
      .hit   (rect_hit[k])
    );
  end

  assign is_chroma = (stage_item.mode == ypm_pkg::MODE_CB) ||
                     (stage_item.mode == ypm_pkg::MODE_CR);

  // Samples that lie beyond the frame of their plane are passed through unmasked
  always_comb begin
    if (probe.is_luma) begin
      in_frame = ({1'b0, stage_item.row} < LUMA_ROWS) &&
                 ({1'b0, stage_item.col} < LUMA_COLS);
    end else begin
      in_frame = ({1'b0, stage_item.row} < CHROMA_ROWS) &&
                 ({1'b0, stage_item.col} < CHROMA_COLS);
    end
  end

  assign hit = mask_enable && (probe.is_luma || is_chroma) && in_frame && (|rect_hit);

  // Replace covered samples with the plane's fill value
  always_comb begin
    out_item_next.covered = hit;
    if (!hit) begin
      out_item_next.sample_out = stage_item.sample_in;
    end else if (probe.is_luma) begin
      out_item_next.sample_out = ypm_pkg::LUMA_FILL;
    end else begin
      out_item_next.sample_out = ypm_pkg::CHROMA_FILL;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_advance) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_advance && stage_valid) begin
      out_item <= out_item_next;
    end
  end

endmodule

// ----- rtl/core/ypm_checker.sv -----
// ----------------------------------------------------------------------------
// ypm_checker
// Port-level checks on the privacy mask block, bound to its top level.
// ----------------------------------------------------------------------------
`include "yuv420_privacy_mask_assert.svh"

module ypm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input ypm_pkg::in_item_t  in_item,
  input logic               out_valid,
  input logic               out_stall,
  input ypm_pkg::out_item_t out_item
);

  // A covered sample carries one of the two fill values
  `YPM_ASSERT_NOW(a_fill_value, out_valid && out_item.covered, out_item.sample_out == ypm_pkg::LUMA_FILL || out_item.sample_out == ypm_pkg::CHROMA_FILL)

  // A fresh result follows an item taken at the input and passed on through the input register
  `YPM_ASSERT_NOW(a_result_has_source, $rose(out_valid), $past(in_valid && !in_stall, 2))

  // Input side stalls only when the output side is blocked
  `YPM_ASSERT_NOW(a_stall_from_output, in_stall, out_valid && out_stall)

  // A stalled result stays put
  `YPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))

  // A stalled input item stays put
  `YPM_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_item))

endmodule

bind yuv420_privacy_mask ypm_checker u_ypm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);
